[rtl/rsa_pkg.sv]
// Shared constants and types for the reference-counted slot allocator.
`default_nettype none
package rsa_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = 6;
    localparam int KEY_W     = 32;
    localparam int REFS_W    = 7;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_HANDLE   = 3'd1;
    localparam logic [2:0] ST_NO_ENTRY    = 3'd2;
    localparam logic [2:0] ST_LOAD_FAIL   = 3'd3;
    localparam logic [2:0] ST_CREATE_FAIL = 3'd4;
    localparam logic [2:0] ST_FREE_REL    = 3'd5;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] data_key;
        logic [IDX_W-1:0] slot_id;
        logic             load_ok;
        logic             create_ok;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] handle;
        logic [IDX_W-1:0] entry_index;
        logic             reused;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [REFS_W-1:0] refs;
    } t_entry;

endpackage
`default_nettype wire

[rtl/rsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/refcounted_shared_slot_allocator.sv]
// Top level of the reference-counted shared slot allocator.
`default_nettype none
// Hands out handles that share reference-counted resource entries keyed by a
// 32-bit data key, one request at a time. An allocate request scans the entry
// memory through its single read port, one entry per cycle. It checks the
// handle in-use bit of the same index in the same pass. The response is
// registered in S_FIN after S_SCAN and S_SCAN_END, once the output register
// is free; the next request can be taken once it is there. A release reads
// the handle's binding and then the bound entry. Its response is registered
// in S_FIN after S_RLS_H, S_RLS_E and S_RLS_D, once the output register is
// free. A release of a free handle goes straight to S_FIN. A new request is
// taken once the previous one has placed its response in the output register,
// even while that response is still stalled. Handle in-use bits and entry
// valid bits are flip-flops cleared by reset; no clearing pass follows reset.
module refcounted_shared_slot_allocator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rsa_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_stall,
    output rsa_pkg::t_rsp      o_rsp
);
    import rsa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_SCAN_END = 7'b0000100,
        S_RLS_H    = 7'b0001000,
        S_RLS_E    = 7'b0010000,
        S_RLS_D    = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    t_state            r_state, n_state;
    t_req              r_req;
    logic [NUM_SLOTS-1:0] r_in_use;
    logic [NUM_SLOTS-1:0] r_ent_vld;
    logic [IDX_W-1:0]  r_idx;
    logic              r_chk;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_have_h;
    logic [IDX_W-1:0]  r_h;
    logic              r_have_hit;
    logic [IDX_W-1:0]  r_hit;
    logic [REFS_W-1:0] r_refs;
    logic [KEY_W-1:0]  r_key;
    logic              r_have_spare;
    logic [IDX_W-1:0]  r_spare;
    logic [IDX_W-1:0]  r_e;
    logic              r_out_vld;
    t_rsp              r_rsp;

    logic              w_accept;
    logic              w_out_free;
    logic              w_fin;
    logic [IDX_W-1:0]  w_ent_raddr;
    t_entry            w_ent_rdata;
    logic              w_ent_we;
    logic [IDX_W-1:0]  w_ent_waddr;
    t_entry            w_ent_wdata;
    logic [IDX_W-1:0]  w_hnd_rdata;
    logic              w_hnd_we;
    logic [REFS_W-1:0] w_chk_refs;
    logic [REFS_W-1:0] w_rd_refs;
    t_rsp              w_rsp;
    logic              w_alloc_ok;
    logic              w_rel_ok;
    logic [IDX_W-1:0]  w_sel_e;
    logic [REFS_W-1:0] w_sel_refs;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_fin      = (r_state == S_FIN) && w_out_free;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_vld;
    assign o_rsp      = r_rsp;

    assign w_ent_raddr = (r_state == S_RLS_E) ? w_hnd_rdata : r_idx;
    assign w_rd_refs   = w_ent_rdata.refs;
    assign w_chk_refs  = r_ent_vld[r_chk_idx] ? w_rd_refs : '0;

    rsa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    rsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_SLOTS)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (w_hnd_we),
        .i_waddr (r_h),
        .i_wdata (w_sel_e),
        .i_raddr (r_req.slot_id),
        .o_rdata (w_hnd_rdata)
    );

    // Response and commit decision.
    always_comb begin
        w_sel_e    = r_have_hit ? r_hit : r_spare;
        w_sel_refs = r_have_hit ? r_refs : '0;
        w_alloc_ok = 1'b0;
        w_rel_ok   = 1'b0;
        w_rsp      = '0;
        if (r_req.req_type == REQ_ALLOC) begin
            priority if (!r_have_h) begin
                w_rsp.status = ST_NO_HANDLE;
            end else if (!r_have_hit && !r_have_spare) begin
                w_rsp.status = ST_NO_ENTRY;
            end else if (!r_have_hit && !r_req.load_ok) begin
                w_rsp.status = ST_LOAD_FAIL;
            end else if (!r_req.create_ok) begin
                w_rsp.status = ST_CREATE_FAIL;
            end else begin
                w_alloc_ok         = 1'b1;
                w_rsp.status       = ST_OK;
                w_rsp.handle       = r_h;
                w_rsp.entry_index  = w_sel_e;
                w_rsp.reused       = r_have_hit;
            end
        end else begin
            w_rsp.handle = r_req.slot_id;
            if (!r_in_use[r_req.slot_id]) begin
                w_rsp.status = ST_FREE_REL;
            end else begin
                w_rel_ok          = 1'b1;
                w_rsp.status      = ST_OK;
                w_rsp.entry_index = r_e;
            end
        end
    end

    always_comb begin
        w_ent_we    = 1'b0;
        w_ent_waddr = w_sel_e;
        w_ent_wdata = '{key: r_req.data_key, refs: w_sel_refs + REFS_W'(1)};
        w_hnd_we    = w_fin && w_alloc_ok;
        if (w_fin && w_alloc_ok) begin
            w_ent_we = 1'b1;
        end else if (w_fin && w_rel_ok && (r_refs != '0)) begin
            w_ent_we    = 1'b1;
            w_ent_waddr = r_e;
            w_ent_wdata = '{key: r_key, refs: r_refs - REFS_W'(1)};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (r_in_use[i_req.slot_id]) begin
                        n_state = S_RLS_H;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: n_state = S_FIN;
            S_RLS_H:    n_state = S_RLS_E;
            S_RLS_E:    n_state = S_RLS_D;
            S_RLS_D:    n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_use  <= '0;
            r_ent_vld <= '0;
            r_out_vld <= 1'b0;
            r_chk     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= (r_state == S_SCAN);
            if (w_fin) begin
                r_out_vld <= 1'b1;
                if (w_alloc_ok) begin
                    r_in_use[r_h]      <= 1'b1;
                    r_ent_vld[w_sel_e] <= 1'b1;
                end
                if (w_rel_ok) begin
                    r_in_use[r_req.slot_id] <= 1'b0;
                end
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (w_fin) begin
            r_rsp <= w_rsp;
        end
        if (w_accept) begin
            r_req        <= i_req;
            r_idx        <= '0;
            r_have_h     <= 1'b0;
            r_have_hit   <= 1'b0;
            r_have_spare <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + IDX_W'(1);
            if (!r_have_h && !r_in_use[r_idx]) begin
                r_have_h <= 1'b1;
                r_h      <= r_idx;
            end
        end
        if (r_chk && !r_have_hit) begin
            if (w_chk_refs != '0) begin
                if (w_ent_rdata.key == r_req.data_key) begin
                    r_have_hit <= 1'b1;
                    r_hit      <= r_chk_idx;
                    r_refs     <= w_chk_refs;
                end
            end else if (!r_have_spare) begin
                r_have_spare <= 1'b1;
                r_spare      <= r_chk_idx;
            end
        end
        if (r_state == S_RLS_E) begin
            r_e <= w_hnd_rdata;
        end
        if (r_state == S_RLS_D) begin
            r_refs <= r_ent_vld[r_e] ? w_rd_refs : '0;
            r_key  <= w_ent_rdata.key;
        end
    end

endmodule
`default_nettype wire
